@@ hw/rtl/tol_pkg.sv @@
// ----------------------------------------------------------------------------
// tol_pkg
// shared widths, codes, control struct and fixed-point helpers for the
// third-order lowpass
// ----------------------------------------------------------------------------
package tol_pkg;

    localparam int unsigned SAMPLE_W   = 24;
    localparam int unsigned COEF_W     = 32;
    localparam int unsigned COEF_FRAC  = COEF_W - 3;
    localparam int unsigned V_FRAC     = 8;
    localparam int unsigned S_FRAC     = 16;
    localparam int unsigned V_W        = SAMPLE_W + V_FRAC;
    localparam int unsigned S_W        = 48;
    localparam int unsigned MUL_W      = 33;
    localparam int unsigned PROD_W     = 64;
    localparam int unsigned WIDE_W     = 66;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 31;

    localparam int unsigned FIRST_B_W  = 30;
    localparam int unsigned FIRST_A1_W = 31;
    localparam int unsigned BI_B0_W    = 28;
    localparam int unsigned BI_A1_W    = 31;
    localparam int unsigned BI_A2_W    = 30;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FIRST_B  = 3'd0,
        REG_FIRST_A1 = 3'd1,
        REG_BI_B0    = 3'd2,
        REG_BI_A1    = 3'd3,
        REG_BI_A2    = 3'd4,
        REG_BYPASS   = 3'd5
    } reg_index_t;

    typedef enum logic {
        OP_FILTER = 1'b0,
        OP_CLEAR  = 1'b1
    } opcode_t;

    // one bit per sequencer step, decoded from the state register
    typedef struct packed {
        logic idle;
        logic mb;
        logic ma;
        logic v;
        logic bv;
        logic y;
        logic m1;
        logic m2;
        logic s2;
        logic done;
    } step_t;

    // round half up, then arithmetic shift right by sh (sh >= 1)
    function automatic logic signed [WIDE_W-1:0] rnd_shr(
        input logic signed [WIDE_W-1:0] v,
        input int unsigned              sh
    );
        logic signed [WIDE_W-1:0] half;
        half = $signed({{(WIDE_W-1){1'b0}}, 1'b1}) <<< (sh - 1);
        return (v + half) >>> sh;
    endfunction

    // clamp to a signed range of w bits
    function automatic logic signed [WIDE_W-1:0] sat_to(
        input logic signed [WIDE_W-1:0] v,
        input int unsigned              w
    );
        logic signed [WIDE_W-1:0] one;
        logic signed [WIDE_W-1:0] hi;
        logic signed [WIDE_W-1:0] lo;
        one = $signed({{(WIDE_W-1){1'b0}}, 1'b1});
        hi  = (one <<< (w - 1)) - one;
        lo  = -hi - one;
        if (v > hi)
        begin
            return hi;
        end
        if (v < lo)
        begin
            return lo;
        end
        return v;
    endfunction

endpackage

@@ hw/rtl/tol_in_if.sv @@
// ----------------------------------------------------------------------------
// tol_in_if
// input item channel: opcode and sample with valid/ready
// ----------------------------------------------------------------------------
interface tol_in_if
    import tol_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic                       opcode;
    logic signed [SAMPLE_W-1:0] sample_in;

    modport source (output valid, output opcode, output sample_in, input ready);
    modport sink   (input valid, input opcode, input sample_in, output ready);
endinterface

@@ hw/rtl/tol_out_if.sv @@
// ----------------------------------------------------------------------------
// tol_out_if
// result item channel: filtered sample with valid/ready
// ----------------------------------------------------------------------------
interface tol_out_if
    import tol_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface

@@ hw/rtl/tol_mul.sv @@
// ----------------------------------------------------------------------------
// tol_mul
// shared signed multiplier with a registered product
// ----------------------------------------------------------------------------
module tol_mul
    import tol_pkg::*;
(
    input  logic                     clk,
    input  logic signed [MUL_W-1:0]  op_a,
    input  logic signed [MUL_W-1:0]  op_b,
    output logic signed [PROD_W-1:0] prod
);

    logic signed [2*MUL_W-1:0] full;
    logic signed [PROD_W-1:0]  prod_reg;

    // every product of the filter fits in the low bits
    assign full = op_a * op_b;

    always_ff @(posedge clk)
    begin
        prod_reg <= full[PROD_W-1:0];
    end

    assign prod = prod_reg;

endmodule

@@ hw/rtl/tol_ctrl.sv @@
// ----------------------------------------------------------------------------
// tol_ctrl
// sequencer that steps the shared multiplier through one sample
// ----------------------------------------------------------------------------
module tol_ctrl
    import tol_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  go_filter,
    input  logic  go_bypass,
    input  logic  out_free,
    output step_t step
);

    typedef enum logic [9:0] {
        ST_IDLE = 10'b00_0000_0001,
        ST_MB   = 10'b00_0000_0010,
        ST_MA   = 10'b00_0000_0100,
        ST_V    = 10'b00_0000_1000,
        ST_BV   = 10'b00_0001_0000,
        ST_Y    = 10'b00_0010_0000,
        ST_M1   = 10'b00_0100_0000,
        ST_M2   = 10'b00_1000_0000,
        ST_S2   = 10'b01_0000_0000,
        ST_DONE = 10'b10_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (go_filter)
                begin
                    state_next = ST_MB;
                end
                else if (go_bypass)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_MB:   state_next = ST_MA;
            ST_MA:   state_next = ST_V;
            ST_V:    state_next = ST_BV;
            ST_BV:   state_next = ST_Y;
            ST_Y:    state_next = ST_M1;
            ST_M1:   state_next = ST_M2;
            ST_M2:   state_next = ST_S2;
            ST_S2:   state_next = ST_DONE;
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign step.idle = (state_reg == ST_IDLE);
    assign step.mb   = (state_reg == ST_MB);
    assign step.ma   = (state_reg == ST_MA);
    assign step.v    = (state_reg == ST_V);
    assign step.bv   = (state_reg == ST_BV);
    assign step.y    = (state_reg == ST_Y);
    assign step.m1   = (state_reg == ST_M1);
    assign step.m2   = (state_reg == ST_M2);
    assign step.s2   = (state_reg == ST_S2);
    assign step.done = (state_reg == ST_DONE);

endmodule

@@ hw/rtl/third_order_lowpass_iir.sv @@
// ----------------------------------------------------------------------------
// third_order_lowpass_iir
// third-order lowpass: first-order section then transposed direct form ii
// biquad, q3.29 coefficients, signed 24-bit samples, saturated output
// ----------------------------------------------------------------------------
// A filtered sample occupies the block from acceptance through the 8
// sequencer steps (MB, MA, V, BV, Y, M1, M2, S2) and the DONE hand-off into
// the output register, and no new sample is accepted until it is through.
// One shared 33x33 multiplier forms the five products of the filter one at a
// time, each registered before use. A sample in bypass goes straight from
// acceptance to the DONE hand-off into the output register, and it leaves the
// filter state untouched; a clear item zeroes the state and gives no result.
// The input is ready only while the sequencer is idle; the output register
// holds a finished result until it is taken, and the next result waits in the
// sequencer if it is still full. Coefficients reset to zero, with bypass set;
// the user must write them through the register port only while the block is
// idle, which the block itself does not enforce.
module third_order_lowpass_iir
    import tol_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    tol_in_if.sink                feed,
    tol_out_if.source             result,
    input  logic                  write_en,
    input  logic [CFG_IDX_W-1:0]  reg_index,
    input  logic [CFG_DATA_W-1:0] write_data
);

    // configuration registers
    logic        [FIRST_B_W-1:0]  first_b_reg;
    logic signed [FIRST_A1_W-1:0] first_a1_reg;
    logic        [BI_B0_W-1:0]    bi_b0_reg;
    logic signed [BI_A1_W-1:0]    bi_a1_reg;
    logic        [BI_A2_W-1:0]    bi_a2_reg;
    logic                         bypass_reg;

    // filter state
    logic signed [SAMPLE_W-1:0]   prev_in_reg;
    logic signed [V_W-1:0]        pfo_reg;
    logic signed [S_W-1:0]        s1_reg;
    logic signed [S_W-1:0]        s2_reg;

    // working registers
    logic signed [SAMPLE_W-1:0]   x_reg;
    logic signed [PROD_W-1:0]     acc_reg;
    logic signed [V_W-1:0]        v_reg;
    logic signed [PROD_W-1:0]     bv_reg;
    logic signed [V_W-1:0]        y8_reg;
    logic signed [SAMPLE_W-1:0]   res_reg;
    logic signed [SAMPLE_W-1:0]   out_reg;
    logic                         out_valid_reg;
    logic                         out_valid_next;

    step_t                        step;
    logic                         accept;
    logic                         go_filter;
    logic                         go_bypass;
    logic                         out_free;
    logic                         out_load;

    logic signed [MUL_W-1:0]      op_a;
    logic signed [MUL_W-1:0]      op_b;
    logic signed [PROD_W-1:0]     prod;

    logic signed [SAMPLE_W:0]     in_sum;
    logic signed [WIDE_W-1:0]     v_diff;
    logic signed [WIDE_W-1:0]     v_full;
    logic signed [WIDE_W-1:0]     bi_acc;
    logic signed [WIDE_W-1:0]     y8_full;
    logic signed [WIDE_W-1:0]     res_full;
    logic signed [WIDE_W-1:0]     s1_diff;
    logic signed [WIDE_W-1:0]     s1_full;
    logic signed [WIDE_W-1:0]     s2_diff;
    logic signed [WIDE_W-1:0]     s2_full;

    // handshake and sequencing
    assign feed.ready = step.idle;
    assign accept     = feed.valid && step.idle;
    assign go_filter  = accept && (feed.opcode == OP_FILTER) && !bypass_reg;
    assign go_bypass  = accept && (feed.opcode == OP_FILTER) && bypass_reg;
    assign out_free   = !out_valid_reg || result.ready;
    assign out_load   = step.done && out_free;

    tol_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .go_filter (go_filter),
        .go_bypass (go_bypass),
        .out_free  (out_free),
        .step      (step)
    );

    // operand selection for the shared multiplier
    assign in_sum = (SAMPLE_W+1)'(x_reg) + (SAMPLE_W+1)'(prev_in_reg);

    always_comb
    begin
        op_a = '0;
        op_b = '0;
        if (step.mb)
        begin
            op_a = $signed({{(MUL_W-FIRST_B_W){1'b0}}, first_b_reg});
            op_b = MUL_W'(in_sum);
        end
        else if (step.ma)
        begin
            op_a = MUL_W'(first_a1_reg);
            op_b = MUL_W'(pfo_reg);
        end
        else if (step.bv)
        begin
            op_a = $signed({{(MUL_W-BI_B0_W){1'b0}}, bi_b0_reg});
            op_b = MUL_W'(v_reg);
        end
        else if (step.m1)
        begin
            op_a = MUL_W'(bi_a1_reg);
            op_b = MUL_W'(y8_reg);
        end
        else if (step.m2)
        begin
            op_a = $signed({{(MUL_W-BI_A2_W){1'b0}}, bi_a2_reg});
            op_b = MUL_W'(y8_reg);
        end
    end

    tol_mul u_mul (
        .clk  (clk),
        .op_a (op_a),
        .op_b (op_b),
        .prod (prod)
    );

    // first-order output: (b*(x+prev)*2^8 - a1*prev_out) / 2^29, rounded
    assign v_diff   = WIDE_W'(acc_reg) - WIDE_W'(prod);
    assign v_full   = sat_to(rnd_shr(v_diff, COEF_FRAC), V_W);

    // biquad accumulator with 16 fraction bits
    assign bi_acc   = rnd_shr(WIDE_W'(prod), COEF_FRAC - V_FRAC) + WIDE_W'(s1_reg);
    assign y8_full  = sat_to(rnd_shr(bi_acc, S_FRAC - V_FRAC), V_W);
    assign res_full = sat_to(rnd_shr(bi_acc, S_FRAC), SAMPLE_W);

    // state updates, old s2 feeds the new s1
    assign s1_diff  = (WIDE_W'(bv_reg) <<< 1) - WIDE_W'(prod);
    assign s1_full  = sat_to(rnd_shr(s1_diff, COEF_FRAC - V_FRAC) + WIDE_W'(s2_reg), S_W);
    assign s2_diff  = WIDE_W'(bv_reg) - WIDE_W'(prod);
    assign s2_full  = sat_to(rnd_shr(s2_diff, COEF_FRAC - V_FRAC), S_W);

    // working registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_reg <= feed.sample_in;
        end
        if (go_bypass)
        begin
            res_reg <= feed.sample_in;
        end
        if (step.ma)
        begin
            acc_reg <= prod <<< V_FRAC;
        end
        if (step.v)
        begin
            v_reg <= v_full[V_W-1:0];
        end
        if (step.y)
        begin
            bv_reg  <= prod;
            y8_reg  <= y8_full[V_W-1:0];
            res_reg <= res_full[SAMPLE_W-1:0];
        end
        if (out_load)
        begin
            out_reg <= res_reg;
        end
    end

    // filter state: cleared by reset and by a clear item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_in_reg <= '0;
            pfo_reg     <= '0;
            s1_reg      <= '0;
            s2_reg      <= '0;
        end
        else if (accept && (feed.opcode == OP_CLEAR))
        begin
            prev_in_reg <= '0;
            pfo_reg     <= '0;
            s1_reg      <= '0;
            s2_reg      <= '0;
        end
        else
        begin
            if (step.v)
            begin
                prev_in_reg <= x_reg;
                pfo_reg     <= v_full[V_W-1:0];
            end
            if (step.m2)
            begin
                s1_reg <= s1_full[S_W-1:0];
            end
            if (step.s2)
            begin
                s2_reg <= s2_full[S_W-1:0];
            end
        end
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.sample_out = out_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_b_reg  <= '0;
            first_a1_reg <= '0;
            bi_b0_reg    <= '0;
            bi_a1_reg    <= '0;
            bi_a2_reg    <= '0;
            bypass_reg   <= 1'b1;
        end
        else if (write_en)
        begin
            case (reg_index_t'(reg_index))
                REG_FIRST_B:  first_b_reg  <= write_data[FIRST_B_W-1:0];
                REG_FIRST_A1: first_a1_reg <= $signed(write_data[FIRST_A1_W-1:0]);
                REG_BI_B0:    bi_b0_reg    <= write_data[BI_B0_W-1:0];
                REG_BI_A1:    bi_a1_reg    <= $signed(write_data[BI_A1_W-1:0]);
                REG_BI_A2:    bi_a2_reg    <= write_data[BI_A2_W-1:0];
                REG_BYPASS:   bypass_reg   <= write_data[0];
                default:      ;
            endcase
        end
    end

    // a sample item keeps the block busy for at least the next cycle
    a_busy_after_sample: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (feed.opcode == OP_FILTER)) |=> !feed.ready)
        else $error("input ready right after a sample item");

    // a clear item leaves all filter state at zero
    a_clear_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (feed.opcode == OP_CLEAR)) |=>
        (prev_in_reg == '0) && (pfo_reg == '0) && (s1_reg == '0) && (s2_reg == '0))
        else $error("filter state not cleared");

    // a bypassed sample leaves the filter state untouched
    a_bypass_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
        go_bypass |=> ($stable(prev_in_reg) && $stable(pfo_reg) &&
        $stable(s1_reg) && $stable(s2_reg)))
        else $error("bypass changed the filter state");

endmodule

@@ verif/tb_third_order_lowpass_iir.sv @@
// ----------------------------------------------------------------------------
// tb_third_order_lowpass_iir
// self-checking bench for the third-order lowpass: a bit-exact fixed-point
// predictor follows every accepted item and the checker compares each result
// in order, while both channels idle and stall at random
// ----------------------------------------------------------------------------
module tb_third_order_lowpass_iir
    import tol_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    // wait after the last result, covering anything still in flight
    localparam int SETTLE_CYCLES = 16;
    localparam int RANDOM_PHASES = 9;
    localparam int PHASE_ITEMS   = 105;

    // q3.29 coefficients for a butterworth section pair at two cutoffs
    // (prewarped k = 0.5 and k = 0.1)
    localparam longint K05_B   = 178956971;
    localparam longint K05_A1F = -178956971;
    localparam longint K05_B0  = 76695845;
    localparam longint K05_A1  = -460175067;
    localparam longint K05_A2  = 230087534;
    localparam longint K01_B   = 48806446;
    localparam longint K01_A1F = -439258018;
    localparam longint K01_B0  = 4836675;
    localparam longint K01_A1  = -957661358;
    localparam longint K01_A2  = 440137404;

    localparam longint SAMPLE_MAX = 8388607;
    localparam longint SAMPLE_MIN = -8388608;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  write_en;
    logic [CFG_IDX_W-1:0]  reg_index;
    logic [CFG_DATA_W-1:0] write_data;

    tol_in_if  feed ();
    tol_out_if result ();

    third_order_lowpass_iir dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .feed       (feed),
        .result     (result),
        .write_en   (write_en),
        .reg_index  (reg_index),
        .write_data (write_data)
    );

    always #5 clk = ~clk;

    // shadow copy of the coefficient registers, at their own widths
    logic [FIRST_B_W-1:0]         cf_first_b;
    logic signed [FIRST_A1_W-1:0] cf_first_a1;
    logic [BI_B0_W-1:0]           cf_bi_b0;
    logic signed [BI_A1_W-1:0]    cf_bi_a1;
    logic [BI_A2_W-1:0]           cf_bi_a2;
    logic                         cf_bypass;

    // predicted filter state: previous input, first-order output (8 fraction
    // bits) and the two biquad delay terms (16 fraction bits)
    longint prev_x;
    longint prev_v;
    longint delay_s1;
    longint delay_s2;

    logic signed [SAMPLE_W-1:0] expected_samples[$];
    logic signed [SAMPLE_W-1:0] oldest_expected;
    logic signed [SAMPLE_W-1:0] last_sample;
    int                         error_count;
    bit                         no_idle;

    // ------------------------------------------------------------------------
    // fixed-point predictor
    // ------------------------------------------------------------------------

    // add half an lsb, then floor-shift
    function automatic longint round_shift(longint v, int sh);
        longint t;
        t = v + (longint'(1) <<< (sh - 1));
        return t >>> sh;
    endfunction

    function automatic longint clamp(longint v, int w);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (w - 1)) - 1;
        lo = -hi - 1;
        if (v > hi)
        begin
            return hi;
        end
        if (v < lo)
        begin
            return lo;
        end
        return v;
    endfunction

    // works out what one accepted item produces and queues it
    function automatic void predict_lowpass(opcode_t op, logic signed [SAMPLE_W-1:0] x_in);
        longint x;
        longint v;
        longint bv;
        longint acc;
        longint y8;
        longint s1_next;
        longint s2_next;
        longint y;
        if (op == OP_CLEAR)
        begin
            // clear zeroes the state whatever bypass says
            prev_x   = 0;
            prev_v   = 0;
            delay_s1 = 0;
            delay_s2 = 0;
            return;
        end
        if (cf_bypass)
        begin
            expected_samples.push_back(x_in);
            return;
        end
        x = longint'(x_in);
        // first-order section, equal numerator taps
        v = longint'(cf_first_b) * (x + prev_x) * 256 - longint'(cf_first_a1) * prev_v;
        v = clamp(round_shift(v, COEF_FRAC), V_W);
        // biquad, transposed direct form ii, numerator b0, 2*b0, b0
        bv  = longint'(cf_bi_b0) * v;
        acc = round_shift(bv, COEF_FRAC - V_FRAC) + delay_s1;
        y8  = clamp(round_shift(acc, S_FRAC - V_FRAC), V_W);
        s1_next = clamp(round_shift(2 * bv - longint'(cf_bi_a1) * y8, COEF_FRAC - V_FRAC)
                        + delay_s2, S_W);
        s2_next = clamp(round_shift(bv - longint'(cf_bi_a2) * y8, COEF_FRAC - V_FRAC), S_W);
        prev_x   = x;
        prev_v   = v;
        delay_s1 = s1_next;
        delay_s2 = s2_next;
        y = clamp(round_shift(acc, S_FRAC), SAMPLE_W);
        expected_samples.push_back(y[SAMPLE_W-1:0]);
    endfunction

    // ------------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------------

    task automatic report_mismatch(string what, logic signed [SAMPLE_W-1:0] got,
                                   logic signed [SAMPLE_W-1:0] want);
        $display("[%0t] mismatch: %s: got %0d, expected %0d", $realtime, what, got, want);
        error_count++;
    endtask

    // every result item taken is compared with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && result.valid === 1'b1 && result.ready === 1'b1)
        begin
            if (expected_samples.size() == 0)
            begin
                report_mismatch("result with nothing outstanding", result.sample_out, '0);
            end
            else
            begin
                oldest_expected = expected_samples.pop_front();
                if (result.sample_out !== oldest_expected)
                begin
                    report_mismatch("sample_out", result.sample_out, oldest_expected);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // channel drivers
    // ------------------------------------------------------------------------

    // idle cycles before the next item on either side
    function automatic int pick_gap();
        if (no_idle)
        begin
            return 0;
        end
        return $urandom_range(0, 16);
    endfunction

    // result side: stall a random number of cycles before each item
    initial
    begin
        int stall;
        result.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = pick_gap();
            if (stall > 0)
            begin
                result.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result.ready <= 1'b1;
            do
                @(posedge clk);
            while (result.valid !== 1'b1);
        end
    end

    // offers one item after a random gap and predicts it once taken;
    // valid stays up so a following item can go out back to back
    task automatic send_item(opcode_t op, logic signed [SAMPLE_W-1:0] smp);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            feed.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        feed.valid     <= 1'b1;
        feed.opcode    <= op;
        feed.sample_in <= smp;
        do
            @(posedge clk);
        while (feed.ready !== 1'b1);
        predict_lowpass(op, smp);
    endtask

    // stop offering, wait for every outstanding sample, then let the block settle
    task automatic await_all_samples();
        feed.valid <= 1'b0;
        while (expected_samples.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // one register write per cycle; the caller drops write_en afterwards
    task automatic write_reg(reg_index_t idx, longint val);
        write_en   <= 1'b1;
        reg_index  <= idx;
        write_data <= val[CFG_DATA_W-1:0];
        case (idx)
            REG_FIRST_B:  cf_first_b  = val[FIRST_B_W-1:0];
            REG_FIRST_A1: cf_first_a1 = val[FIRST_A1_W-1:0];
            REG_BI_B0:    cf_bi_b0    = val[BI_B0_W-1:0];
            REG_BI_A1:    cf_bi_a1    = val[BI_A1_W-1:0];
            REG_BI_A2:    cf_bi_a2    = val[BI_A2_W-1:0];
            REG_BYPASS:   cf_bypass   = val[0];
            default:      ;
        endcase
        @(posedge clk);
    endtask

    // rewrites the whole register set; only called with the block idle
    task automatic program_filter(longint fb, longint fa1, longint b0, longint a1,
                                  longint a2, logic byp);
        write_reg(REG_FIRST_B, fb);
        write_reg(REG_FIRST_A1, fa1);
        write_reg(REG_BI_B0, b0);
        write_reg(REG_BI_A1, a1);
        write_reg(REG_BI_A2, a2);
        write_reg(REG_BYPASS, longint'(byp));
        write_en <= 1'b0;
    endtask

    // mostly full-range noise, with small values, both rails and held values
    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        logic signed [SAMPLE_W-1:0] s;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: s = SAMPLE_W'($urandom);
            5, 6:          s = SAMPLE_W'($signed($urandom_range(0, 511)) - 256);
            7:             s = SAMPLE_MAX[SAMPLE_W-1:0];
            8:             s = SAMPLE_MIN[SAMPLE_W-1:0];
            default:       s = last_sample;
        endcase
        last_sample = s;
        return s;
    endfunction

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // straight after reset bypass is set: samples come back unchanged,
    // a clear gives nothing back
    task automatic test_bypass_after_reset();
        send_item(OP_FILTER, SAMPLE_MIN[SAMPLE_W-1:0]);
        send_item(OP_FILTER, SAMPLE_MAX[SAMPLE_W-1:0]);
        send_item(OP_FILTER, 24'sh000000);
        send_item(OP_CLEAR, 24'sh555555);
        send_item(OP_FILTER, -24'sd1);
        send_item(OP_FILTER, 24'sh555555);
        send_item(OP_FILTER, 24'shAAAAAA);
        await_all_samples();
    endtask

    // impulse through a stable filter, then bypass leaving state alone and
    // a clear issued while in bypass
    task automatic test_filter_directed();
        program_filter(K05_B, K05_A1F, K05_B0, K05_A1, K05_A2, 1'b0);
        send_item(OP_FILTER, SAMPLE_MAX[SAMPLE_W-1:0]);
        send_item(OP_FILTER, 24'sh000000);
        send_item(OP_FILTER, 24'sh000000);
        send_item(OP_FILTER, SAMPLE_MIN[SAMPLE_W-1:0]);
        send_item(OP_FILTER, -24'sd1);
        await_all_samples();
        program_filter(K05_B, K05_A1F, K05_B0, K05_A1, K05_A2, 1'b1);
        send_item(OP_FILTER, 24'sh123456);
        send_item(OP_CLEAR, 24'sh000000);
        await_all_samples();
        program_filter(K05_B, K05_A1F, K05_B0, K05_A1, K05_A2, 1'b0);
        send_item(OP_FILTER, SAMPLE_MAX[SAMPLE_W-1:0]);
        send_item(OP_FILTER, 24'sh000000);
        await_all_samples();
    endtask

    // coefficients that put the poles on the unit circle make the
    // intermediate values and the output run into their limits
    task automatic test_saturation();
        program_filter(536870912, -536870912, 134217728, -1073741824, 536870912, 1'b0);
        send_item(OP_FILTER, SAMPLE_MAX[SAMPLE_W-1:0]);
        send_item(OP_FILTER, SAMPLE_MAX[SAMPLE_W-1:0]);
        send_item(OP_FILTER, SAMPLE_MAX[SAMPLE_W-1:0]);
        send_item(OP_FILTER, SAMPLE_MIN[SAMPLE_W-1:0]);
        send_item(OP_FILTER, SAMPLE_MIN[SAMPLE_W-1:0]);
        send_item(OP_FILTER, SAMPLE_MIN[SAMPLE_W-1:0]);
        await_all_samples();
    endtask

    // random streams over a series of coefficient sets; halfway through each
    // set the source holds off until the block has drained
    task automatic test_random_streams();
        int      phase;
        int      i;
        opcode_t op;
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            // one set in four runs with no idling on either side
            no_idle = (phase % 4 == 2);
            await_all_samples();
            case (phase)
                0:
                    // bypass with live coefficients
                    program_filter($urandom_range(0, 536870912),
                                   longint'($urandom_range(0, 1073741824)) - 536870912,
                                   $urandom_range(0, 134217728),
                                   longint'($urandom_range(0, 2147483647)) - 1073741824,
                                   $urandom_range(0, 536870912), 1'b1);
                1:
                    program_filter(K05_B, K05_A1F, K05_B0, K05_A1, K05_A2, 1'b0);
                2:
                    program_filter(K01_B, K01_A1F, K01_B0, K01_A1, K01_A2, 1'b0);
                4:
                    // any bit pattern the registers hold
                    program_filter($urandom, $urandom, $urandom, $urandom, $urandom, 1'b0);
                5:
                    // upper extremes of every range
                    program_filter(536870912, 536870912, 134217728, 1073741823,
                                   536870912, 1'b0);
                6:
                    program_filter(0, 0, 0, 0, 0, 1'b0);
                7:
                    // lower extremes of the signed ranges, numerators full
                    program_filter(536870912, -536870912, 134217728, -1073741824, 0, 1'b0);
                default:
                    program_filter($urandom_range(0, 536870912),
                                   longint'($urandom_range(0, 1073741824)) - 536870912,
                                   $urandom_range(0, 134217728),
                                   longint'($urandom_range(0, 2147483647)) - 1073741824,
                                   $urandom_range(0, 536870912), 1'b0);
            endcase
            for (i = 0; i < PHASE_ITEMS; i++)
            begin
                if (i == PHASE_ITEMS / 2)
                begin
                    await_all_samples();
                    // last set flips bypass mid-stream to show the state survives
                    if (phase == RANDOM_PHASES - 1)
                    begin
                        program_filter(cf_first_b, cf_first_a1, cf_bi_b0, cf_bi_a1,
                                       cf_bi_a2, ~cf_bypass);
                    end
                end
                op = ($urandom_range(0, 15) == 0) ? OP_CLEAR : OP_FILTER;
                send_item(op, pick_sample());
            end
        end
        no_idle = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------

    initial
    begin
        // every input known from time zero, reset held low before the tests start
        rst_n          = 1'b0;
        feed.valid     = 1'b0;
        feed.opcode    = OP_FILTER;
        feed.sample_in = '0;
        write_en       = 1'b0;
        reg_index      = REG_FIRST_B;
        write_data     = '0;
        error_count    = 0;
        no_idle        = 1'b0;
        last_sample    = '0;
        // register and state values after reset
        cf_first_b  = '0;
        cf_first_a1 = '0;
        cf_bi_b0    = '0;
        cf_bi_a1    = '0;
        cf_bi_a2    = '0;
        cf_bypass   = 1'b1;
        prev_x      = 0;
        prev_v      = 0;
        delay_s1    = 0;
        delay_s2    = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_bypass_after_reset();
        test_filter_directed();
        test_saturation();
        test_random_streams();

        // all stimulus taken: wait out the last results and any stragglers
        await_all_samples();
        if (error_count == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

    // run limit, well above the slowest correct run
    initial
    begin
        #5000000;
        $display("FAILURE");
        $finish;
    end

endmodule
